>>> sv/jrve_pkg.sv
package jrve_pkg;

    localparam int KEY_MAX_DEF    = 16;
    localparam int DEPTH_BITS_DEF = 8;
    localparam int QUEUE_DEPTH    = 4;
    localparam int KEY_REG_BYTES  = 16;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [1:0] ST_BYTE  = 2'd0;
    localparam logic [1:0] ST_FOUND = 2'd1;
    localparam logic [1:0] ST_MISS  = 2'd2;

    localparam logic [1:0] CMD_OPEN = 2'd0;
    localparam logic [1:0] CMD_BYTE = 2'd1;
    localparam logic [1:0] CMD_MISS = 2'd2;

    localparam logic [1:0] CFG_KEY_LEN = 2'd0;
    localparam logic [1:0] CFG_KEY_LO  = 2'd1;
    localparam logic [1:0] CFG_KEY_HI  = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic pend_valid;
        logic value_open;
    } back_status_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    function automatic logic is_scalar_end(input logic [7:0] b);
        return (b == CH_COMMA) || (b == CH_RBRACE) || (b == CH_RBRACK);
    endfunction

endpackage

>>> sv/jrve_front.sv
module jrve_front import jrve_pkg::*; #(
    parameter int KEY_MAX = KEY_MAX_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_doc_byte,
    input  logic        s_doc_last,
    output logic        q_valid,
    input  logic        q_ready,
    output cmd_t        q_data
);

    localparam int WIN = KEY_MAX + 1;
    localparam int LW  = ($clog2(KEY_MAX + 3) > 5) ? $clog2(KEY_MAX + 3) : 5;

    localparam logic [2:0] F_SEARCH = 3'd0;
    localparam logic [2:0] F_COLON  = 3'd1;
    localparam logic [2:0] F_WS     = 3'd2;
    localparam logic [2:0] F_FWD    = 3'd3;
    localparam logic [2:0] F_DONE   = 3'd4;

    logic [4:0]     key_len_reg;
    logic [63:0]    key_lo_reg;
    logic [63:0]    key_hi_reg;
    logic [2:0]     phase_reg, phase_next;
    logic [LW-1:0]  cnt_reg, cnt_next;
    logic [7:0]     win_reg [WIN];

    logic           accept;
    logic           shift;
    logic           match;
    logic [LW-1:0]  klen;
    logic [LW-1:0]  cnt_inc;
    logic [127:0]   key_all;

    assign s_ready = q_ready;
    assign accept  = s_valid && q_ready;
    assign key_all = {key_hi_reg, key_lo_reg};

    always_comb begin
        klen = LW'(key_len_reg);
        if (klen > LW'(KEY_MAX)) begin
            klen = LW'(KEY_MAX);
        end
        cnt_inc = (cnt_reg < LW'(KEY_MAX + 2)) ? cnt_reg + LW'(1) : cnt_reg;
    end

    // The current byte is the closing quote; older bytes sit in the window.
    always_comb begin
        logic [LW-1:0] idx;
        logic [7:0]    kb;
        match = (s_doc_byte == CH_DQUOTE) && (cnt_inc >= klen + LW'(2));
        for (int j = 1; j <= KEY_MAX + 1; j++) begin
            idx = klen - LW'(j);
            kb  = (idx < LW'(KEY_REG_BYTES)) ? key_all[{idx[3:0], 3'b000} +: 8] : 8'h00;
            if (LW'(j) <= klen) begin
                if (win_reg[j-1] != kb) begin
                    match = 1'b0;
                end
            end else if (LW'(j) == klen + LW'(1)) begin
                if (win_reg[j-1] != CH_DQUOTE) begin
                    match = 1'b0;
                end
            end
        end
    end

    always_comb begin
        q_valid     = 1'b0;
        q_data.cmd  = CMD_BYTE;
        q_data.data = s_doc_byte;
        q_data.last = s_doc_last;
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        shift       = 1'b0;
        if (accept) begin
            unique case (phase_reg)
                F_SEARCH: begin
                    shift    = 1'b1;
                    cnt_next = cnt_inc;
                    if (match) begin
                        phase_next = F_COLON;
                    end
                end
                F_COLON: begin
                    if (s_doc_byte == CH_COLON) begin
                        phase_next = F_WS;
                    end
                end
                F_WS: begin
                    if (!is_ws(s_doc_byte)) begin
                        q_valid = 1'b1;
                        if (is_scalar_end(s_doc_byte)) begin
                            q_data.cmd = CMD_MISS;
                            phase_next = F_DONE;
                        end else begin
                            q_data.cmd = CMD_OPEN;
                            phase_next = F_FWD;
                        end
                    end
                end
                F_FWD: begin
                    q_valid = 1'b1;
                end
                F_DONE: begin
                end
                default: begin
                    phase_next = F_SEARCH;
                end
            endcase
            if (s_doc_last) begin
                if (!q_valid && phase_reg != F_DONE) begin
                    q_valid    = 1'b1;
                    q_data.cmd = CMD_MISS;
                end
                phase_next = F_SEARCH;
                cnt_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_len_reg <= '0;
            key_lo_reg  <= '0;
            key_hi_reg  <= '0;
            phase_reg   <= F_SEARCH;
            cnt_reg     <= '0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_KEY_LEN: key_len_reg <= cfg_wdata[4:0];
                    CFG_KEY_LO:  key_lo_reg  <= cfg_wdata;
                    CFG_KEY_HI:  key_hi_reg  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (shift) begin
            win_reg[0] <= s_doc_byte;
            for (int i = 1; i < WIN; i++) begin
                win_reg[i] <= win_reg[i-1];
            end
        end
    end

endmodule

>>> sv/jrve_fifo.sv
module jrve_fifo import jrve_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  cmd_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output cmd_t rd_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_wr, do_rd;

    assign wr_ready = (cnt_reg != CW'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_wr && !do_rd) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (do_rd && !do_wr) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> sv/jrve_back.sv
module jrve_back import jrve_pkg::*; #(
    parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         q_valid,
    output logic         q_ready,
    input  cmd_t         q_data,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [7:0]   m_value_byte,
    output logic [1:0]   m_status,
    output logic         m_last,
    output back_status_t bstat
);

    localparam logic [1:0] B_IDLE   = 2'd0;
    localparam logic [1:0] B_NEST   = 2'd1;
    localparam logic [1:0] B_QUOTE  = 2'd2;
    localparam logic [1:0] B_SCALAR = 2'd3;

    localparam logic [1:0] K_BRACE  = 2'd0;
    localparam logic [1:0] K_BRACK  = 2'd1;
    localparam logic [1:0] K_DQUOTE = 2'd2;
    localparam logic [1:0] K_SQUOTE = 2'd3;

    localparam logic [DEPTH_BITS-1:0] NEST_MAX = {DEPTH_BITS{1'b1}};

    logic [1:0]            phase_reg, phase_next;
    logic [1:0]            kind_reg, kind_next;
    logic [DEPTH_BITS-1:0] nest_reg, nest_next;
    logic                  esc_reg, esc_next;
    logic                  pend_reg, pend_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_byte_reg, out_byte_next;
    logic [1:0]            out_status_reg, out_status_next;
    logic                  out_last_reg, out_last_next;

    logic                  have0, have1;
    logic [7:0]            r0_byte;
    logic [1:0]            r0_status;
    logic                  r0_last;
    logic                  end_found;
    logic [7:0]            b;
    logic [7:0]            open_ch, close_ch, quote_ch;
    logic                  out_free;
    logic                  pop;

    assign b        = q_data.data;
    assign open_ch  = (kind_reg == K_BRACE) ? CH_LBRACE : CH_LBRACK;
    assign close_ch = (kind_reg == K_BRACE) ? CH_RBRACE : CH_RBRACK;
    assign quote_ch = (kind_reg == K_SQUOTE) ? CH_SQUOTE : CH_DQUOTE;
    assign out_free = !out_valid_reg || m_ready;

    // Work out the results and the new value state for the request at the head.
    always_comb begin
        have0      = 1'b0;
        r0_byte    = b;
        r0_status  = ST_BYTE;
        r0_last    = 1'b0;
        end_found  = 1'b0;
        phase_next = phase_reg;
        kind_next  = kind_reg;
        nest_next  = nest_reg;
        esc_next   = esc_reg;
        unique case (q_data.cmd)
            CMD_MISS: begin
                have0      = 1'b1;
                r0_byte    = 8'h00;
                r0_status  = ST_MISS;
                r0_last    = 1'b1;
                phase_next = B_IDLE;
            end
            CMD_OPEN: begin
                have0 = 1'b1;
                if (b == CH_LBRACE || b == CH_LBRACK) begin
                    phase_next = B_NEST;
                    kind_next  = (b == CH_LBRACE) ? K_BRACE : K_BRACK;
                    nest_next  = DEPTH_BITS'(1);
                end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
                    phase_next = B_QUOTE;
                    kind_next  = (b == CH_DQUOTE) ? K_DQUOTE : K_SQUOTE;
                    esc_next   = 1'b0;
                end else begin
                    phase_next = B_SCALAR;
                end
            end
            CMD_BYTE: begin
                unique case (phase_reg)
                    B_NEST: begin
                        have0 = 1'b1;
                        if (b == open_ch) begin
                            if (nest_reg != NEST_MAX) begin
                                nest_next = nest_reg + DEPTH_BITS'(1);
                            end
                        end else if (b == close_ch) begin
                            if (nest_reg != '0) begin
                                nest_next = nest_reg - DEPTH_BITS'(1);
                            end
                            if (nest_next == '0) begin
                                end_found  = 1'b1;
                                phase_next = B_IDLE;
                            end
                        end
                    end
                    B_QUOTE: begin
                        have0 = 1'b1;
                        if (esc_reg) begin
                            esc_next = 1'b0;
                        end else if (b == CH_BSLASH) begin
                            esc_next = 1'b1;
                        end else if (b == quote_ch) begin
                            end_found  = 1'b1;
                            phase_next = B_IDLE;
                        end
                    end
                    B_SCALAR: begin
                        if (is_scalar_end(b)) begin
                            end_found  = 1'b1;
                            phase_next = B_IDLE;
                        end else begin
                            have0 = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
        if (q_data.last) begin
            if (phase_next != B_IDLE) begin
                end_found = 1'b1;
            end
            phase_next = B_IDLE;
        end
        have1 = 1'b0;
        if (end_found) begin
            if (have0) begin
                have1 = 1'b1;
            end else begin
                have0     = 1'b1;
                r0_byte   = 8'h00;
                r0_status = ST_FOUND;
                r0_last   = 1'b1;
            end
        end
    end

    always_comb begin
        pop             = 1'b0;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_byte_next   = out_byte_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        if (pend_reg) begin
            if (out_free) begin
                out_valid_next  = 1'b1;
                out_byte_next   = 8'h00;
                out_status_next = ST_FOUND;
                out_last_next   = 1'b1;
                pend_next       = 1'b0;
            end
        end else if (q_valid && (out_free || !have0)) begin
            pop = 1'b1;
            if (have0) begin
                out_valid_next  = 1'b1;
                out_byte_next   = r0_byte;
                out_status_next = r0_status;
                out_last_next   = r0_last;
                pend_next       = have1;
            end
        end
    end

    assign q_ready = pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= B_IDLE;
            kind_reg      <= K_BRACE;
            nest_reg      <= '0;
            esc_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                phase_reg <= phase_next;
                kind_reg  <= kind_next;
                nest_reg  <= nest_next;
                esc_reg   <= esc_next;
            end
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg   <= out_byte_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_value_byte     = out_byte_reg;
    assign m_status         = out_status_reg;
    assign m_last           = out_last_reg;
    assign bstat.pend_valid = pend_reg;
    assign bstat.value_open = (phase_reg != B_IDLE);

endmodule

>>> sv/json_raw_value_extract_top.sv
// Extracts the raw value of one key from a stream of document text.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_index (0 key
// length, 1 key bytes 0-7, 2 key bytes 8-15); the user must write only while
// idle, unchecked by the block. Input channel s_*: one document byte per
// request, s_doc_last on the final byte. A byte is taken in every cycle while
// the four-entry queue between the scanner and the value copier has room.
// Result channel m_*: value bytes with status 0, then one end result per
// document (status 1 found, 2 not found) with m_last set.
// The command for a byte is registered in the queue, and its result then in the output register.
// Throughput: one byte per cycle while the queue has room; a byte that causes
// two results (a closing brace, bracket or quote, or a final byte that closes
// a value) holds the copier for its second result; the queue absorbs that.
// Reset clears the key registers and all document state.
// When the receiver stalls, the output register holds its result, the queue
// fills and s_ready falls once it is full.
module json_raw_value_extract_top import jrve_pkg::*; #(
    parameter int KEY_MAX    = KEY_MAX_DEF,
    parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_doc_byte,
    input  logic        s_doc_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_value_byte,
    output logic [1:0]  m_status,
    output logic        m_last
);

    logic         fq_valid, fq_ready;
    cmd_t         fq_data;
    logic         qb_valid, qb_ready;
    cmd_t         qb_data;
    back_status_t bstat;

    jrve_front #(
        .KEY_MAX (KEY_MAX)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_doc_byte (s_doc_byte),
        .s_doc_last (s_doc_last),
        .q_valid    (fq_valid),
        .q_ready    (fq_ready),
        .q_data     (fq_data)
    );

    jrve_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    jrve_back #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (qb_valid),
        .q_ready      (qb_ready),
        .q_data       (qb_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value_byte (m_value_byte),
        .m_status     (m_status),
        .m_last       (m_last),
        .bstat        (bstat)
    );

    // A second result is only ever held behind a result already on the output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        bstat.pend_valid |-> m_valid)
        else $error("pending end result without a result on the output");

    // The held second result always closes the value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        bstat.pend_valid |-> !bstat.value_open)
        else $error("value still open while an end result is pending");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_BYTE) |-> m_last)
        else $error("end result without last");

endmodule
